// File: sv/tdph_pkg.sv
`timescale 1ns / 1ps
package tdph_pkg;

    localparam int MAX_X_BINS_DEF = 128;
    localparam int MAX_Z_BINS_DEF = 256;
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS      = 8;

    localparam int POS_W = 24;
    localparam int OFF_W = 26;
    localparam int IDX_W = 21;
    localparam int CFG_W = 24;

    localparam logic [1:0] CMD_PARTICLE   = 2'd0;
    localparam logic [1:0] CMD_READ_CLEAR = 2'd1;
    localparam logic [1:0] CMD_NEW_FRAME  = 2'd2;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    localparam logic [2:0] ST_COUNTED = 3'd0;
    localparam logic [2:0] ST_SKIPPED = 3'd1;
    localparam logic [2:0] ST_OUT     = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_FRAME   = 3'd4;

    localparam logic [2:0] CFG_X_CENTER    = 3'd0;
    localparam logic [2:0] CFG_Z_CENTER    = 3'd1;
    localparam logic [2:0] CFG_X_LOW_EDGE  = 3'd2;
    localparam logic [2:0] CFG_Z_LOW_EDGE  = 3'd3;
    localparam logic [2:0] CFG_BIN_SHIFT   = 3'd4;
    localparam logic [2:0] CFG_X_BINS_USED = 3'd5;
    localparam logic [2:0] CFG_Z_BINS_USED = 3'd6;
    localparam logic [2:0] CFG_SKIP_COUNT  = 3'd7;

    localparam logic signed [POS_W-1:0] X_LOW_EDGE_RST = POS_W'(-(21 << FRAC_BITS));
    localparam logic signed [POS_W-1:0] Z_LOW_EDGE_RST = POS_W'(-(40 << FRAC_BITS));
    localparam logic [4:0]  BIN_SHIFT_RST   = 5'((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0);
    localparam logic [7:0]  X_BINS_USED_RST = 8'd84;
    localparam logic [8:0]  Z_BINS_USED_RST = 9'd160;
    localparam logic [19:0] SKIP_COUNT_RST  = 20'd14442;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_z;
        logic [7:0]              read_row;
        logic [6:0]              read_col;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] bin_count;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic accept;
        logic offset_en;
        logic bin_en;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: sv/tdph_ram.sv
`timescale 1ns / 1ps
module tdph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/tdph_ctrl.sv
`timescale 1ns / 1ps
module tdph_ctrl import tdph_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OFFSET,
        S_BIN,
        S_READ,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_OFFSET;
                end
            end
            S_OFFSET: begin
                o_cmd.offset_en = 1'b1;
                n_state = S_BIN;
            end
            S_BIN: begin
                o_cmd.bin_en = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: sv/tdph_dp.sv
`timescale 1ns / 1ps
module tdph_dp import tdph_pkg::*; #(
    parameter int MAX_X_BINS = MAX_X_BINS_DEF,
    parameter int MAX_Z_BINS = MAX_Z_BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_in_item         i_in_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_data
);

    localparam int CELLS = MAX_X_BINS * MAX_Z_BINS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic signed [POS_W-1:0] r_x_center;
    logic signed [POS_W-1:0] r_z_center;
    logic signed [POS_W-1:0] r_x_low_edge;
    logic signed [POS_W-1:0] r_z_low_edge;
    logic [4:0]              r_bin_shift;
    logic [7:0]              r_x_used;
    logic [8:0]              r_z_used;
    logic [19:0]             r_skip_count;

    logic [1:0]              r_command;
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_z;
    logic [7:0]              r_read_row;
    logic [6:0]              r_read_col;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_skip;
    logic signed [OFF_W-1:0] r_off_x;
    logic signed [OFF_W-1:0] r_off_z;
    logic [2:0]              r_status;
    logic [AW-1:0]           r_addr;
    logic [AW-1:0]           r_clr_addr;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic signed [OFF_W-1:0] w_off_x;
    logic signed [OFF_W-1:0] w_off_z;
    logic [OFF_W-1:0]        w_bin_x;
    logic [OFF_W-1:0]        w_bin_z;
    logic [31:0]             w_x_lim;
    logic [31:0]             w_z_lim;
    logic                    w_hit;
    logic                    w_read_ok;
    logic [31:0]             w_p_addr;
    logic [31:0]             w_r_addr;
    logic [2:0]              w_status;
    logic [COUNT_BITS-1:0]   w_rdata;
    logic [COUNT_BITS-1:0]   w_new;
    logic [COUNT_BITS-1:0]   w_count;
    logic [31:0]             w_count32;
    logic                    w_we;
    logic [COUNT_BITS-1:0]   w_wdata;
    logic [AW-1:0]           w_ram_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_center   <= '0;
            r_z_center   <= '0;
            r_x_low_edge <= X_LOW_EDGE_RST;
            r_z_low_edge <= Z_LOW_EDGE_RST;
            r_bin_shift  <= BIN_SHIFT_RST;
            r_x_used     <= X_BINS_USED_RST;
            r_z_used     <= Z_BINS_USED_RST;
            r_skip_count <= SKIP_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_X_CENTER:    r_x_center   <= i_cfg_wdata;
                CFG_Z_CENTER:    r_z_center   <= i_cfg_wdata;
                CFG_X_LOW_EDGE:  r_x_low_edge <= i_cfg_wdata;
                CFG_Z_LOW_EDGE:  r_z_low_edge <= i_cfg_wdata;
                CFG_BIN_SHIFT:   r_bin_shift  <= i_cfg_wdata[4:0];
                CFG_X_BINS_USED: r_x_used     <= i_cfg_wdata[7:0];
                CFG_Z_BINS_USED: r_z_used     <= i_cfg_wdata[8:0];
                CFG_SKIP_COUNT:  r_skip_count <= i_cfg_wdata[19:0];
                default:         r_skip_count <= r_skip_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.accept) begin
            if (i_in_data.command == CMD_NEW_FRAME) begin
                r_idx <= '0;
            end else if (i_in_data.command == CMD_PARTICLE && r_idx != '1) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_command  <= i_in_data.command;
            r_pos_x    <= i_in_data.pos_x;
            r_pos_z    <= i_in_data.pos_z;
            r_read_row <= i_in_data.read_row;
            r_read_col <= i_in_data.read_col;
            r_skip     <= (r_idx < IDX_W'(r_skip_count));
        end
        if (i_cmd.offset_en) begin
            r_off_x <= w_off_x;
            r_off_z <= w_off_z;
        end
        if (i_cmd.bin_en) begin
            r_status <= w_status;
            r_addr   <= (r_command == CMD_PARTICLE) ? AW'(w_p_addr) : AW'(w_r_addr);
        end
    end

    assign w_off_x = OFF_W'(r_pos_x) - OFF_W'(r_x_center) - OFF_W'(r_x_low_edge);
    assign w_off_z = OFF_W'(r_pos_z) - OFF_W'(r_z_center) - OFF_W'(r_z_low_edge);

    assign w_bin_x = $unsigned(r_off_x) >> r_bin_shift;
    assign w_bin_z = $unsigned(r_off_z) >> r_bin_shift;

    assign w_x_lim = (32'(r_x_used) < 32'(MAX_X_BINS)) ? 32'(r_x_used) : 32'(MAX_X_BINS);
    assign w_z_lim = (32'(r_z_used) < 32'(MAX_Z_BINS)) ? 32'(r_z_used) : 32'(MAX_Z_BINS);

    assign w_hit = !r_off_x[OFF_W-1] && !r_off_z[OFF_W-1]
                   && (32'(w_bin_x) < w_x_lim) && (32'(w_bin_z) < w_z_lim);
    assign w_read_ok = (32'(r_read_row) < 32'(MAX_Z_BINS))
                       && (32'(r_read_col) < 32'(MAX_X_BINS));

    assign w_p_addr = 32'(w_bin_z) * 32'(MAX_X_BINS) + 32'(w_bin_x);
    assign w_r_addr = 32'(r_read_row) * 32'(MAX_X_BINS) + 32'(r_read_col);

    always_comb begin
        unique case (r_command)
            CMD_PARTICLE:   w_status = r_skip ? ST_SKIPPED : (w_hit ? ST_COUNTED : ST_OUT);
            CMD_READ_CLEAR: w_status = w_read_ok ? ST_READ : ST_OUT;
            CMD_NEW_FRAME:  w_status = ST_FRAME;
            CMD_UNUSED:     w_status = ST_OUT;
            default:        w_status = ST_OUT;
        endcase
    end

    assign w_new = (w_rdata == '1) ? w_rdata : w_rdata + 1'b1;

    always_comb begin
        if (r_status == ST_COUNTED) begin
            w_count = w_new;
        end else if (r_status == ST_READ) begin
            w_count = w_rdata;
        end else begin
            w_count = '0;
        end
    end
    assign w_count32 = 32'(w_count);

    assign w_we = i_cmd.clear
                  || (i_cmd.commit && (r_status == ST_COUNTED || r_status == ST_READ));
    assign w_wdata = (!i_cmd.clear && r_status == ST_COUNTED) ? w_new : '0;
    assign w_ram_addr = i_cmd.clear ? r_clr_addr : r_addr;

    tdph_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data.status    <= r_status;
            r_out_data.bin_count <= w_count32[15:0];
        end
    end

    assign o_stat.clear_last = (r_clr_addr == AW'(CELLS - 1));
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// File: sv/two_d_position_histogram_core.sv
`timescale 1ns / 1ps
// Two-dimensional position histogram. Each particle transfer is binned by
// (pos - center - low_edge) >> bin_shift on both axes and bumps a saturating
// count in a MAX_Z_BINS x MAX_X_BINS single-port memory; the first skip_count
// particles of a frame are only reported as skipped, and bins outside the used
// range come back as out of bounds. A read-and-clear transfer returns one bin
// and zeroes it, a new-frame transfer restarts the particle index. Every input
// transfer yields exactly one result. Each item goes through offset, bin and
// address, memory read, then write-back into the output register, which waits
// while a stalled result is held; with the one memory port a new item is taken
// only after the last is written back. After reset the memory is zeroed one
// entry per cycle, all MAX_X_BINS * MAX_Z_BINS entries (32768 by default),
// with the input stalled; configuration writes are taken during that time.
module two_d_position_histogram_core import tdph_pkg::*; #(
    parameter int MAX_X_BINS = MAX_X_BINS_DEF,
    parameter int MAX_Z_BINS = MAX_Z_BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    t_dp_cmd  s_cmd;
    t_dp_stat s_stat;

    tdph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    tdph_dp #(
        .MAX_X_BINS (MAX_X_BINS),
        .MAX_Z_BINS (MAX_Z_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_stall_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input not stalled during memory clear");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.commit |-> !(o_out_valid && i_out_stall))
        else $error("result written over a waiting result");

    a_rise_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s_cmd.commit))
        else $error("result appeared without a commit");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.clear |-> !s_cmd.accept && !s_cmd.commit)
        else $error("item handled during memory clear");

endmodule
